[src/pvia_pkg.sv]
package pvia_pkg;

	localparam int ERROR_WIDTH_DEF = 16;
	localparam int SUM_WIDTH_DEF   = 24;

	localparam int DUTY_W     = 16;
	localparam int GAIN_W     = 16;
	localparam int LIMIT_W    = 23;
	localparam int OUT_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam int RAMP_LOW    = 691;
	localparam int RAMP_HIGH   = 742;
	localparam int RAMP_NUM    = 3712;
	localparam int DUTY_MARGIN = 20;

	localparam logic [DUTY_W-1:0]  DUTY_MAX_RST    = 16'd1660;
	localparam logic [DUTY_W-1:0]  DUTY_MIN_RST    = 16'd1275;
	localparam logic [DUTY_W-1:0]  DUTY_REL_RST    = 16'd1500;
	localparam logic [LIMIT_W-1:0] SUM_LIMIT_RST   = 23'd38400;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOOP_MODE   = 3'd0,
		REG_GAIN_P      = 3'd1,
		REG_GAIN_I      = 3'd2,
		REG_GAIN_D      = 3'd3,
		REG_DUTY_MAX    = 3'd4,
		REG_DUTY_MIN    = 3'd5,
		REG_DUTY_REL    = 3'd6,
		REG_SUM_LIMIT   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic               loop_mode;
		logic [GAIN_W-1:0]  gain_p;
		logic [GAIN_W-1:0]  gain_i;
		logic [GAIN_W-1:0]  gain_d;
		logic [DUTY_W-1:0]  duty_max;
		logic [DUTY_W-1:0]  duty_min;
		logic [DUTY_W-1:0]  duty_low_release;
		logic [LIMIT_W-1:0] sum_limit;
	} cfg_t;

	typedef enum logic [1:0] {
		MUL_P = 2'd0,
		MUL_I = 2'd1,
		MUL_D = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     calc_term;
		logic     upd_sum;
		mul_sel_t mul_sel;
		logic     acc_load;
		logic     acc_add;
		logic     load_out;
	} cmd_t;

endpackage

[src/pvia_regs.sv]
module pvia_regs
	import pvia_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.loop_mode        <= 1'b0;
			cfg_q.gain_p           <= '0;
			cfg_q.gain_i           <= '0;
			cfg_q.gain_d           <= '0;
			cfg_q.duty_max         <= DUTY_MAX_RST;
			cfg_q.duty_min         <= DUTY_MIN_RST;
			cfg_q.duty_low_release <= DUTY_REL_RST;
			cfg_q.sum_limit        <= SUM_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_LOOP_MODE: cfg_q.loop_mode        <= cfg_data[0];
				REG_GAIN_P:    cfg_q.gain_p           <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:    cfg_q.gain_i           <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:    cfg_q.gain_d           <= cfg_data[GAIN_W-1:0];
				REG_DUTY_MAX:  cfg_q.duty_max         <= cfg_data[DUTY_W-1:0];
				REG_DUTY_MIN:  cfg_q.duty_min         <= cfg_data[DUTY_W-1:0];
				REG_DUTY_REL:  cfg_q.duty_low_release <= cfg_data[DUTY_W-1:0];
				REG_SUM_LIMIT: cfg_q.sum_limit        <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/pvia_ctrl.sv]
module pvia_ctrl
	import pvia_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TERM,
		ST_SUM,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_ACC,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_TERM;
					end
				end
				ST_TERM:  state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_MUL_P;
				ST_MUL_P: state_q <= ST_MUL_I;
				ST_MUL_I: state_q <= ST_MUL_D;
				ST_MUL_D: state_q <= ST_ACC;
				ST_ACC:   state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.mul_sel   = MUL_P;
		case (state_q)
			ST_IDLE:  cmd.load_in   = in_valid;
			ST_TERM:  cmd.calc_term = 1'b1;
			ST_SUM:   cmd.upd_sum   = 1'b1;
			ST_MUL_P: cmd.mul_sel   = MUL_P;
			ST_MUL_I: begin
				cmd.mul_sel  = MUL_I;
				cmd.acc_load = 1'b1;
			end
			ST_MUL_D: begin
				cmd.mul_sel = MUL_D;
				cmd.acc_add = 1'b1;
			end
			ST_ACC:   cmd.acc_add   = 1'b1;
			ST_FIN:   cmd.load_out  = out_free;
			default: ;
		endcase
	end

endmodule

[src/pvia_dp.sv]
module pvia_dp
	import pvia_pkg::*;
#(
	parameter int ERROR_WIDTH = ERROR_WIDTH_DEF,
	parameter int SUM_WIDTH   = SUM_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmd_t                          cmd,
	input  cfg_t                          cfg,
	input  logic signed [ERROR_WIDTH-1:0] error_sample,
	input  logic [DUTY_W-1:0]             duty_now,
	output logic signed [OUT_W-1:0]       drive_value
);

	localparam int EW  = ERROR_WIDTH;
	localparam int AW  = (EW + 1 > 11) ? EW + 1 : 11;
	localparam int DW  = (EW > 12) ? EW : 12;
	localparam int SWA = (SUM_WIDTH > DW) ? SUM_WIDTH : DW;
	localparam int SW2 = ((SWA > 24) ? SWA : 24) + 1;
	localparam int MW  = (EW + 1 > SUM_WIDTH) ? EW + 1 : SUM_WIDTH;
	localparam int PW  = MW + GAIN_W;
	localparam int ACW = PW + 2;
	localparam int XW  = (ACW > 41) ? ACW : 41;

	logic signed [EW-1:0]        e_q;
	logic [DUTY_W-1:0]           duty_q;
	logic signed [EW-1:0]        prev_q;
	logic signed [EW:0]          diff_q;
	logic signed [DW-1:0]        delta_q;
	logic signed [SUM_WIDTH-1:0] sum_q;
	logic signed [PW-1:0]        prod_q;
	logic signed [ACW-1:0]       acc_q;
	logic signed [OUT_W-1:0]     drive_q;

	// integral term
	logic signed [EW:0]   e_ext;
	logic [EW:0]          a_full;
	logic [AW-1:0]        a_cmp;
	logic [9:0]           a10;
	logic [11:0]          ramp_rem;
	logic [21:0]          ramp_prod;
	logic [13:0]          ramp_mag;
	logic signed [DW-1:0] mag_s;
	logic signed [DW-1:0] term;
	logic signed [DW-1:0] delta;
	logic                 e_neg;
	logic                 e_pos;
	logic [DUTY_W:0]      duty_hi;
	logic                 take;

	assign e_ext     = (EW+1)'(e_q);
	assign e_neg     = e_q[EW-1];
	assign e_pos     = !e_q[EW-1] && (e_q != '0);
	assign a_full    = e_neg ? $unsigned(-e_ext) : $unsigned(e_ext);
	assign a_cmp     = AW'(a_full);
	assign a10       = a_cmp[9:0];
	assign ramp_rem  = 12'(RAMP_NUM) - ({a10, 2'b00} + 12'(a10));
	assign ramp_prod = 22'(a10) * 22'(ramp_rem);
	assign ramp_mag  = ramp_prod[21:8];
	assign mag_s     = DW'($signed({1'b0, ramp_mag}));

	always_comb begin
		if (a_cmp <= AW'(RAMP_LOW)) begin
			term = DW'(e_q);
		end else if (a_cmp <= AW'(RAMP_HIGH)) begin
			term = e_neg ? -mag_s : mag_s;
		end else begin
			term = '0;
		end
	end

	assign duty_hi = {1'b0, duty_q} + (DUTY_W+1)'(DUTY_MARGIN);
	assign take    = ((duty_hi >= {1'b0, cfg.duty_max}) && e_neg)
		|| ((duty_q <= cfg.duty_low_release) && e_pos)
		|| ((duty_q <= cfg.duty_max) && (duty_q >= cfg.duty_min));

	always_comb begin
		if (!cfg.loop_mode) begin
			delta = DW'(e_q);
		end else if (take) begin
			delta = term;
		end else begin
			delta = '0;
		end
	end

	// sum update with width saturation and, in loop mode, clamp to sum_limit
	logic signed [SW2-1:0]       s_add;
	logic [SW2-SUM_WIDTH:0]      s_hi;
	logic signed [SUM_WIDTH-1:0] s_sat;
	logic signed [SW2-1:0]       s_w;
	logic signed [SW2-1:0]       lim;
	logic signed [SUM_WIDTH-1:0] sum_next;

	assign s_add = SW2'(sum_q) + SW2'(delta_q);
	assign s_hi  = s_add[SW2-1:SUM_WIDTH-1];

	always_comb begin
		if ((&s_hi) || !(|s_hi)) begin
			s_sat = s_add[SUM_WIDTH-1:0];
		end else if (s_add[SW2-1]) begin
			s_sat = {1'b1, {(SUM_WIDTH-1){1'b0}}};
		end else begin
			s_sat = {1'b0, {(SUM_WIDTH-1){1'b1}}};
		end
	end

	assign s_w = SW2'(s_sat);
	assign lim = SW2'($signed({1'b0, cfg.sum_limit}));

	always_comb begin
		if (cfg.loop_mode && (s_w > lim)) begin
			sum_next = SUM_WIDTH'(lim);
		end else if (cfg.loop_mode && (s_w < -lim)) begin
			sum_next = SUM_WIDTH'(-lim);
		end else begin
			sum_next = s_sat;
		end
	end

	// shared multiplier
	logic signed [GAIN_W-1:0] mul_a;
	logic signed [MW-1:0]     mul_b;
	logic signed [PW-1:0]     mul_p;

	always_comb begin
		case (cmd.mul_sel)
			MUL_P: begin
				mul_a = $signed(cfg.gain_p);
				mul_b = MW'(e_q);
			end
			MUL_I: begin
				mul_a = $signed(cfg.gain_i);
				mul_b = MW'(sum_q);
			end
			MUL_D: begin
				mul_a = $signed(cfg.gain_d);
				mul_b = MW'(diff_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = PW'(mul_a) * PW'(mul_b);

	// output scaling and saturation
	logic signed [XW-1:0]    acc_x;
	logic signed [XW-1:0]    acc_sh;
	logic [XW-OUT_W:0]       o_hi;
	logic signed [OUT_W-1:0] drive_next;

	assign acc_x  = XW'(acc_q);
	assign acc_sh = acc_x >>> 8;
	assign o_hi   = acc_sh[XW-1:OUT_W-1];

	always_comb begin
		if ((&o_hi) || !(|o_hi)) begin
			drive_next = acc_sh[OUT_W-1:0];
		end else if (acc_sh[XW-1]) begin
			drive_next = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			drive_next = {1'b0, {(OUT_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			e_q    <= error_sample;
			duty_q <= duty_now;
		end
		if (cmd.calc_term) begin
			delta_q <= delta;
			diff_q  <= (EW+1)'(e_q) - (EW+1)'(prev_q);
		end
		prod_q <= mul_p;
		if (cmd.acc_load) begin
			acc_q <= ACW'(prod_q);
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + ACW'(prod_q);
		end
		if (cmd.load_out) begin
			drive_q <= drive_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			sum_q  <= '0;
		end else begin
			if (cmd.upd_sum) begin
				sum_q <= sum_next;
			end
			if (cmd.load_out) begin
				prev_q <= e_q;
			end
		end
	end

	assign drive_value = drive_q;

endmodule

[src/pid_variable_integral_antiwindup_top.sv]
// pid controller with variable-speed integration and integral anti-windup
//
// input stream (s_*): one transaction carries an error sample and the current
// duty value; output stream (m_*): one transaction carries the drive value
// for each input transaction, in order.
// configuration: cfg_wr_en, cfg_index and cfg_data write one register per
// cycle; write only while no transaction is in flight.
//
// sequence: after input acceptance the controller runs term, sum update and
// three products through one shared multiplier, then accumulates and finishes;
// a new transaction is accepted only once the previous one has left the sequence.
// s_tready is high only while the sequencer is idle.
// the output register lets a new input be accepted while a result waits; if
// the receiver stalls, the sequence holds in its last step until the output
// register is free, and s_tready stays low meanwhile.
// reset: arst_n clears the integral sum, the previous error, the output valid,
// returns the sequencer to idle and sets the config registers to their reset values.
module pid_variable_integral_antiwindup_top
	import pvia_pkg::*;
#(
	parameter int ERROR_WIDTH = ERROR_WIDTH_DEF,
	parameter int SUM_WIDTH   = SUM_WIDTH_DEF,
	localparam int IN_W       = ((ERROR_WIDTH + DUTY_W + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,  // error_sample, duty_now
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,  // drive_value
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                          cfg;
	cmd_t                          cmd;
	logic signed [OUT_W-1:0]       drive_value;
	logic signed [ERROR_WIDTH-1:0] error_sample;
	logic [DUTY_W-1:0]             duty_now;

	assign error_sample = $signed(s_tdata[ERROR_WIDTH-1:0]);
	assign duty_now     = s_tdata[ERROR_WIDTH+DUTY_W-1:ERROR_WIDTH];

	pvia_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pvia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	pvia_dp #(
		.ERROR_WIDTH (ERROR_WIDTH),
		.SUM_WIDTH   (SUM_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.error_sample (error_sample),
		.duty_now     (duty_now),
		.drive_value  (drive_value)
	);

	assign m_tdata = drive_value;

endmodule
